/* design/tek_vector_stream_encoder_core_defines.svh */
// Assertion macros shared by the vector stream encoder modules.
// No dependencies; included by every module that carries assertions.
`ifndef TEK_VECTOR_STREAM_ENCODER_CORE_DEFINES_SVH
`define TEK_VECTOR_STREAM_ENCODER_CORE_DEFINES_SVH

// same-cycle implication, off while reset is high
`define TVSE_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tvse assertion failed");

// next-cycle implication, off while reset is high
`define TVSE_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tvse assertion failed");

`endif

/* design/tvse_pkg.sv */
// Types, byte codes and sequencing functions of the vector stream encoder.
// No dependencies; used by every other file of the block.
package tvse_pkg;

  localparam int COORD_BITS = 12;

  typedef logic [COORD_BITS-1:0] coord_t;

  // item kinds
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_LINE  = 2'd1;
  localparam logic [1:0] FUNC_TEXT  = 2'd2;
  localparam logic [1:0] FUNC_END   = 2'd3;

  // terminal control bytes
  localparam logic [7:0] BYTE_ESC = 8'h1B;
  localparam logic [7:0] BYTE_GS  = 8'h1D;
  localparam logic [7:0] BYTE_BEL = 8'h07;
  localparam logic [7:0] BYTE_US  = 8'h1F;

  // high bits of the offset codes (0x20, 0x40, 0x60, 0x38)
  localparam logic [2:0] HI_20 = 3'b001;
  localparam logic [2:0] HI_40 = 3'b010;
  localparam logic [2:0] HI_60 = 3'b011;
  localparam logic [3:0] HI_60_NIB = 4'b0110;
  localparam logic [4:0] HI_LSTYLE = 5'b01100;
  localparam logic [5:0] HI_FSTYLE = 6'b001110;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_VECTOR,
    MODE_ALPHA
  } draw_mode_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ENTER,
    PH_EXIT,
    PH_STYLE,
    PH_MOVE,
    PH_MODE,
    PH_ADDR,
    PH_CHAR
  } phase_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] style;
    coord_t     start_x;
    coord_t     start_y;
    coord_t     end_x;
    coord_t     end_y;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  // classified item, as queued between front and back
  typedef struct packed {
    in_item_t item;
    logic     style_chg;
    logic     moved;
    logic     mode_chg;
  } job_t;

  function automatic logic [7:0] enter_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h1B;
      3'd1:    b = 8'h5B;
      3'd2:    b = 8'h3F;
      3'd3:    b = 8'h33;
      3'd4:    b = 8'h38;
      3'd5:    b = 8'h68;
      3'd6:    b = 8'h1B;
      default: b = 8'h0C;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] exit_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h0D;
      4'd1:    b = 8'h1B;
      4'd2:    b = 8'h03;
      4'd3:    b = 8'h1B;
      4'd4:    b = 8'h5B;
      4'd5:    b = 8'h3F;
      4'd6:    b = 8'h33;
      4'd7:    b = 8'h38;
      default: b = 8'h6C;
    endcase
    return b;
  endfunction

  // one byte of the five-byte terminal address
  function automatic logic [7:0] addr_byte(input coord_t x, input coord_t y,
                                           input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = {HI_20, y[11:7]};
      3'd1:    b = {HI_60_NIB, y[1:0], x[1:0]};
      3'd2:    b = {HI_60, y[6:2]};
      3'd3:    b = {HI_20, x[11:7]};
      default: b = {HI_40, x[6:2]};
    endcase
    return b;
  endfunction

  function automatic logic [3:0] phase_len(input phase_t ph, input logic is_text);
    logic [3:0] n;
    case (ph)
      PH_ENTER: n = 4'd8;
      PH_EXIT:  n = 4'd9;
      PH_STYLE: n = 4'd2;
      PH_MOVE:  n = 4'd6;
      PH_MODE:  n = is_text ? 4'd1 : 4'd2;
      PH_ADDR:  n = 4'd5;
      default:  n = 4'd1;
    endcase
    return n;
  endfunction

  function automatic phase_t final_phase(input job_t j);
    return (j.item.func == FUNC_TEXT) ? PH_CHAR : PH_ADDR;
  endfunction

  function automatic phase_t first_phase(input job_t j);
    phase_t p;
    case (j.item.func)
      FUNC_START: p = PH_ENTER;
      FUNC_END:   p = PH_EXIT;
      default: begin
        if (j.style_chg)     p = PH_STYLE;
        else if (j.moved)    p = PH_MOVE;
        else if (j.mode_chg) p = PH_MODE;
        else                 p = final_phase(j);
      end
    endcase
    return p;
  endfunction

  // PH_IDLE marks the end of the item
  function automatic phase_t next_phase(input job_t j, input phase_t ph);
    phase_t p;
    case (ph)
      PH_STYLE: begin
        if (j.moved)         p = PH_MOVE;
        else if (j.mode_chg) p = PH_MODE;
        else                 p = final_phase(j);
      end
      PH_MOVE:  p = j.mode_chg ? PH_MODE : final_phase(j);
      PH_MODE:  p = final_phase(j);
      default:  p = PH_IDLE;
    endcase
    return p;
  endfunction

endpackage

/* design/tvse_stream_if.sv */
// Valid/ready channel carrying one payload item per handshake.
// Payload type is a parameter; used with tvse_pkg structs.
interface tvse_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* design/tvse_queue.sv */
// Small FIFO of classified items between the front and back ends.
// Depends on tvse_pkg and the assertion macro header.
`include "tek_vector_stream_encoder_core_defines.svh"

module tvse_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tvse_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output tvse_pkg::job_t head,
  output logic          not_empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  tvse_pkg::job_t entries [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  `TVSE_ASSERT_NOW(a_no_pop_empty, clk, rst, pop, count != '0)
  `TVSE_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_FULL)
endmodule

/* design/tvse_front.sv */
// Front end: accepts items, compares them with the remembered terminal state
// and queues a classified job. Depends on tvse_pkg, tvse_stream_if, macros.
`include "tek_vector_stream_encoder_core_defines.svh"

module tvse_front (
  input  logic           clk,
  input  logic           rst,
  tvse_stream_if.sink    item_ch,
  input  logic           q_full,
  output logic           push,
  output tvse_pkg::job_t push_job
);
  logic                    line_valid, line_valid_next;
  logic [7:0]              line_seen, line_seen_next;
  logic                    font_valid, font_valid_next;
  logic [7:0]              font_seen, font_seen_next;
  tvse_pkg::coord_t        pen_x, pen_x_next;
  tvse_pkg::coord_t        pen_y, pen_y_next;
  logic                    pen_known, pen_known_next;
  tvse_pkg::draw_mode_t    mode, mode_next;

  tvse_pkg::in_item_t      it;
  tvse_pkg::draw_mode_t    mode_mid;
  logic                    style_chg;
  logic                    moved;
  logic                    mode_chg;

  assign it            = item_ch.payload;
  assign item_ch.ready = !q_full;
  assign push          = item_ch.valid && !q_full;

  always_comb begin
    line_valid_next = line_valid;
    line_seen_next  = line_seen;
    font_valid_next = font_valid;
    font_seen_next  = font_seen;
    pen_x_next      = pen_x;
    pen_y_next      = pen_y;
    pen_known_next  = pen_known;
    mode_next       = mode;
    style_chg       = 1'b0;
    mode_chg        = 1'b0;
    mode_mid        = mode;
    moved = !pen_known || (pen_x != it.start_x) || (pen_y != it.start_y);

    unique case (it.func)
      tvse_pkg::FUNC_START: begin
        line_valid_next = 1'b0;
        line_seen_next  = '0;
        font_valid_next = 1'b0;
        font_seen_next  = '0;
        pen_x_next      = '0;
        pen_y_next      = '0;
        pen_known_next  = 1'b0;
        mode_next       = tvse_pkg::MODE_NONE;
      end
      tvse_pkg::FUNC_LINE: begin
        style_chg = !line_valid || (line_seen != it.style);
        if (style_chg) begin
          mode_mid = tvse_pkg::MODE_NONE;
        end
        mode_chg        = (mode_mid != tvse_pkg::MODE_VECTOR);
        line_valid_next = 1'b1;
        line_seen_next  = it.style;
        mode_next       = tvse_pkg::MODE_VECTOR;
        pen_x_next      = it.end_x;
        pen_y_next      = it.end_y;
        pen_known_next  = 1'b1;
      end
      tvse_pkg::FUNC_TEXT: begin
        style_chg = !font_valid || (font_seen != it.style);
        if (style_chg || moved) begin
          mode_mid = tvse_pkg::MODE_NONE;
        end
        mode_chg        = (mode_mid != tvse_pkg::MODE_ALPHA);
        font_valid_next = 1'b1;
        font_seen_next  = it.style;
        mode_next       = tvse_pkg::MODE_ALPHA;
        pen_x_next      = it.start_x;
        pen_y_next      = it.start_y;
        pen_known_next  = 1'b1;
      end
      tvse_pkg::FUNC_END: begin
        // trailer only, state untouched
      end
    endcase

    push_job.item      = it;
    push_job.style_chg = style_chg;
    push_job.moved     = moved;
    push_job.mode_chg  = mode_chg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= 1'b0;
      line_seen  <= '0;
      font_valid <= 1'b0;
      font_seen  <= '0;
      pen_x      <= '0;
      pen_y      <= '0;
      pen_known  <= 1'b0;
      mode       <= tvse_pkg::MODE_NONE;
    end else if (push) begin
      line_valid <= line_valid_next;
      line_seen  <= line_seen_next;
      font_valid <= font_valid_next;
      font_seen  <= font_seen_next;
      pen_x      <= pen_x_next;
      pen_y      <= pen_y_next;
      pen_known  <= pen_known_next;
      mode       <= mode_next;
    end
  end

  `TVSE_ASSERT_NEXT(a_line_vector, clk, rst, push && (it.func == tvse_pkg::FUNC_LINE), mode == tvse_pkg::MODE_VECTOR && pen_known)
  `TVSE_ASSERT_NEXT(a_start_clears, clk, rst, push && (it.func == tvse_pkg::FUNC_START), !pen_known && !line_valid && !font_valid)
endmodule

/* design/tvse_back.sv */
// Back end: walks the byte phases of each queued job and drives the output
// register. Depends on tvse_pkg, tvse_stream_if and the macro header.
`include "tek_vector_stream_encoder_core_defines.svh"

module tvse_back (
  input  logic           clk,
  input  logic           rst,
  input  tvse_pkg::job_t head,
  input  logic           head_valid,
  output logic           pop,
  tvse_stream_if.source  byte_ch
);
  tvse_pkg::phase_t phase, phase_next, after;
  logic [3:0]       cnt, cnt_next;
  logic [3:0]       len;
  tvse_pkg::job_t   job, job_next;
  logic             out_valid;
  tvse_pkg::out_item_t out_reg;
  logic [7:0]       cur_byte;
  logic             room;
  logic             advance;
  logic             seg_done;
  logic             item_done;

  assign byte_ch.valid   = out_valid;
  assign byte_ch.payload = out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= tvse_pkg::PH_IDLE;
      cnt   <= '0;
    end else begin
      phase <= phase_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    job <= job_next;
  end

  always_comb begin
    len       = tvse_pkg::phase_len(phase, job.item.func == tvse_pkg::FUNC_TEXT);
    seg_done  = (cnt == len - 4'd1);
    after     = tvse_pkg::next_phase(job, phase);
    room      = !out_valid || byte_ch.ready;
    advance   = (phase != tvse_pkg::PH_IDLE) && room;
    item_done = advance && seg_done && (after == tvse_pkg::PH_IDLE);
    pop       = head_valid && ((phase == tvse_pkg::PH_IDLE) || item_done);

    unique case (phase)
      tvse_pkg::PH_ENTER: cur_byte = tvse_pkg::enter_byte(cnt[2:0]);
      tvse_pkg::PH_EXIT:  cur_byte = tvse_pkg::exit_byte(cnt);
      tvse_pkg::PH_STYLE: begin
        if (cnt == 4'd0) begin
          cur_byte = tvse_pkg::BYTE_ESC;
        end else if (job.item.func == tvse_pkg::FUNC_TEXT) begin
          cur_byte = {tvse_pkg::HI_FSTYLE, job.item.style[1:0]};
        end else begin
          cur_byte = {tvse_pkg::HI_LSTYLE, job.item.style[2:0]};
        end
      end
      tvse_pkg::PH_MOVE: begin
        if (cnt == 4'd0) begin
          cur_byte = tvse_pkg::BYTE_GS;
        end else begin
          cur_byte = tvse_pkg::addr_byte(job.item.start_x, job.item.start_y,
                                         3'(cnt - 4'd1));
        end
      end
      tvse_pkg::PH_MODE: begin
        if (job.item.func == tvse_pkg::FUNC_TEXT) begin
          cur_byte = tvse_pkg::BYTE_US;
        end else begin
          cur_byte = (cnt == 4'd0) ? tvse_pkg::BYTE_GS : tvse_pkg::BYTE_BEL;
        end
      end
      tvse_pkg::PH_ADDR:
        cur_byte = tvse_pkg::addr_byte(job.item.end_x, job.item.end_y, cnt[2:0]);
      tvse_pkg::PH_CHAR:  cur_byte = job.item.char_code;
      default:            cur_byte = '0;
    endcase

    phase_next = phase;
    cnt_next   = cnt;
    job_next   = job;
    if (pop) begin
      job_next   = head;
      phase_next = tvse_pkg::first_phase(head);
      cnt_next   = '0;
    end else if (advance) begin
      if (seg_done) begin
        phase_next = after;
        cnt_next   = '0;
      end else begin
        cnt_next = cnt + 4'd1;
      end
    end
  end

  // output register: decouples the sequencer from the downstream stall
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (byte_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg.out_byte    <= cur_byte;
      out_reg.last_of_run <= seg_done && (after == tvse_pkg::PH_IDLE);
    end
  end

  `TVSE_ASSERT_NOW(a_cnt_in_phase, clk, rst, phase != tvse_pkg::PH_IDLE, cnt < len)
  `TVSE_ASSERT_NEXT(a_last_flag, clk, rst, item_done, out_valid && out_reg.last_of_run)
endmodule

/* design/tek_vector_stream_encoder_core.sv */
// Vector terminal stream encoder: display-list items in, terminal bytes out.
// An accepted item reaches the output via queue entry, job register, output register.
// Throughput: one byte per cycle on the output while the receiver is ready; an item is
// 1 to 15 bytes long, all sent through the single-byte output register.
// Up to QUEUE_DEPTH classified items wait between front and back end.
// Reset (rst, synchronous): forgets styles, pen and mode, empties the queue.
module tek_vector_stream_encoder_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  tvse_stream_if.sink   item_ch,
  tvse_stream_if.source byte_ch
);
  // Front end keeps the terminal state (styles, pen, vector/alpha mode) and
  // decides at accept time which optional groups each item needs: style
  // escape, dark move, mode switch. Those flags travel with the item.
  tvse_pkg::job_t push_job;
  logic           push;
  logic           q_full;

  // Back end pulls jobs from the queue and emits one byte per cycle while byte_ch is ready.
  tvse_pkg::job_t head;
  logic           head_valid;
  logic           pop;

  tvse_front u_front (
    .clk      (clk),
    .rst      (rst),
    .item_ch  (item_ch),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // Queue lets the front keep accepting items while the back is still
  // streaming the bytes of earlier ones.
  tvse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_job),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .not_empty (head_valid)
  );

  // The back end loads the next job in the same cycle as the last byte of
  // the current one, so queued items stream without gaps.
  tvse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .byte_ch    (byte_ch)
  );
endmodule

/* tb/tek_vector_stream_encoder_core_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for tek_vector_stream_encoder_core: directed items then random sessions.
// Depends on tvse_pkg and tvse_stream_if; the expected byte stream comes from a local predictor.
module tek_vector_stream_encoder_core_test;
  import tvse_pkg::*;

  localparam int          RANDOM_ITEMS    = 300;
  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int          DRAIN_CYCLES    = 40;
  localparam int          CYCLE_LIMIT     = 1000000;
  localparam int          MAX_REPORTS     = 10;

  // terminal preamble and trailer, first byte in the top bits
  localparam logic [63:0] ENTER_SEQ = 64'h1B_5B_3F_33_38_68_1B_0C;
  localparam logic [71:0] EXIT_SEQ  = 72'h0D_1B_03_1B_5B_3F_33_38_6C;

  // offsets of the address and style bytes
  localparam logic [7:0]  ADDR_HI_BASE    = 8'h20;
  localparam logic [7:0]  ADDR_LOY_BASE   = 8'h60;
  localparam logic [7:0]  ADDR_LOX_BASE   = 8'h40;
  localparam logic [7:0]  LINE_STYLE_BASE = 8'h60;
  localparam logic [7:0]  FONT_STYLE_BASE = 8'h38;

  // one row of the directed table; golden bytes right-aligned, first byte highest
  typedef struct packed {
    in_item_t     item;
    logic [3:0]   n_gold;
    logic [119:0] gold;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tvse_stream_if #(.payload_t(in_item_t))  item_ch ();
  tvse_stream_if #(.payload_t(out_item_t)) byte_ch ();

  tek_vector_stream_encoder_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .item_ch (item_ch),
    .byte_ch (byte_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state: what the terminal has been told so far
  logic       ls_valid;
  logic [7:0] ls_code;
  logic       fs_valid;
  logic [7:0] fs_code;
  coord_t     pen_x_q;
  coord_t     pen_y_q;
  logic       pen_known_q;
  draw_mode_t mode_q;

  logic [7:0] run_bytes[$];      // bytes of the item being predicted
  out_item_t  expected_bytes[$]; // bytes still owed by the block
  stim_row_t  directed_rows[$];

  // pacing shared by driver and receiver
  bit calm          = 1'b0;
  bit hold_off_req  = 1'b0;
  bit hold_off_done = 1'b0;

  int mismatches    = 0;
  int bytes_checked = 0;
  int items_sent    = 0;
  int kind_count[4] = '{0, 0, 0, 0};

  function automatic void forget_state();
    ls_valid    = 1'b0;
    ls_code     = '0;
    fs_valid    = 1'b0;
    fs_code     = '0;
    pen_x_q     = '0;
    pen_y_q     = '0;
    pen_known_q = 1'b0;
    mode_q      = MODE_NONE;
  endfunction

  // five-byte terminal address: hi y, extra low bits, lo y, hi x, lo x
  function automatic void add_addr(input coord_t x, input coord_t y);
    run_bytes.push_back(ADDR_HI_BASE + {3'b000, y[11:7]});
    run_bytes.push_back(ADDR_LOY_BASE + {4'b0000, y[1:0], x[1:0]});
    run_bytes.push_back(ADDR_LOY_BASE + {3'b000, y[6:2]});
    run_bytes.push_back(ADDR_HI_BASE + {3'b000, x[11:7]});
    run_bytes.push_back(ADDR_LOX_BASE + {3'b000, x[6:2]});
  endfunction

  // bytes caused by one item, and the state change it makes
  function automatic void encode_item(input in_item_t it);
    logic relocate;
    int   k;
    relocate = !pen_known_q || pen_x_q != it.start_x || pen_y_q != it.start_y;
    run_bytes.delete();
    case (it.func)
      FUNC_START: begin
        for (k = 0; k < 8; k++) run_bytes.push_back(ENTER_SEQ[(7 - k) * 8 +: 8]);
        forget_state();
      end
      FUNC_END: begin
        // trailer only, state kept
        for (k = 0; k < 9; k++) run_bytes.push_back(EXIT_SEQ[(8 - k) * 8 +: 8]);
      end
      FUNC_LINE: begin
        if (!ls_valid || ls_code != it.style) begin
          run_bytes.push_back(BYTE_ESC);
          run_bytes.push_back(LINE_STYLE_BASE + {5'b00000, it.style[2:0]});
          ls_valid = 1'b1;
          ls_code  = it.style;
          mode_q   = MODE_NONE;
        end
        // a dark move leaves the mode alone for lines
        if (relocate) begin
          run_bytes.push_back(BYTE_GS);
          add_addr(it.start_x, it.start_y);
        end
        if (mode_q != MODE_VECTOR) begin
          run_bytes.push_back(BYTE_GS);
          run_bytes.push_back(BYTE_BEL);
          mode_q = MODE_VECTOR;
        end
        add_addr(it.end_x, it.end_y);
        pen_x_q     = it.end_x;
        pen_y_q     = it.end_y;
        pen_known_q = 1'b1;
      end
      FUNC_TEXT: begin
        if (!fs_valid || fs_code != it.style) begin
          run_bytes.push_back(BYTE_ESC);
          run_bytes.push_back(FONT_STYLE_BASE + {6'b000000, it.style[1:0]});
          fs_valid = 1'b1;
          fs_code  = it.style;
          mode_q   = MODE_NONE;
        end
        // a text move drops out of both modes; pen stays put after the glyph
        if (relocate) begin
          run_bytes.push_back(BYTE_GS);
          add_addr(it.start_x, it.start_y);
          pen_x_q     = it.start_x;
          pen_y_q     = it.start_y;
          pen_known_q = 1'b1;
          mode_q      = MODE_NONE;
        end
        if (mode_q != MODE_ALPHA) begin
          run_bytes.push_back(BYTE_US);
          mode_q = MODE_ALPHA;
        end
        run_bytes.push_back(it.char_code);
      end
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(16, 40);
  endfunction

  function automatic coord_t rand_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return '0;
    if (r < 24) return '1;
    return coord_t'($urandom_range(0, 4095));
  endfunction

  function automatic in_item_t rand_fields();
    in_item_t it;
    it.func      = 2'($urandom_range(0, 3));
    it.style     = 8'($urandom_range(0, 255));
    it.start_x   = rand_coord();
    it.start_y   = rand_coord();
    it.end_x     = rand_coord();
    it.end_y     = rand_coord();
    it.char_code = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // line or text item that often continues from the pen and keeps its style
  function automatic in_item_t make_body();
    in_item_t it;
    logic     keep_style;
    it         = rand_fields();
    it.func    = ($urandom_range(0, 99) < 60) ? FUNC_LINE : FUNC_TEXT;
    keep_style = ($urandom_range(0, 99) < 65);
    if (it.func == FUNC_LINE && ls_valid && keep_style) it.style = ls_code;
    if (it.func == FUNC_TEXT && fs_valid && keep_style) it.style = fs_code;
    if (pen_known_q && $urandom_range(0, 99) < 60) begin
      it.start_x = pen_x_q;
      it.start_y = pen_y_q;
    end
    return it;
  endfunction

  function automatic void add_row(input logic [1:0] func, input logic [7:0] style,
                                  input coord_t sx, input coord_t sy,
                                  input coord_t ex, input coord_t ey,
                                  input logic [7:0] ch, input int n_gold,
                                  input logic [119:0] gold);
    stim_row_t r;
    r.item.func      = func;
    r.item.style     = style;
    r.item.start_x   = sx;
    r.item.start_y   = sy;
    r.item.end_x     = ex;
    r.item.end_y     = ey;
    r.item.char_code = ch;
    r.n_gold         = 4'(n_gold);
    r.gold           = gold;
    directed_rows.push_back(r);
  endfunction

  // offer one item, hold it until taken, then queue the bytes it owes
  task automatic send_item(input in_item_t it, input int n_gold, input logic [119:0] gold);
    int        gap;
    int        k;
    out_item_t e;
    gap = pick_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid   <= 1'b1;
    item_ch.payload <= it;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    encode_item(it);
    if (n_gold > 0) begin
      // typed-in bytes replace the prediction; state still follows the predictor
      run_bytes.delete();
      for (k = 0; k < n_gold; k++) run_bytes.push_back(gold[(n_gold - 1 - k) * 8 +: 8]);
    end
    for (k = 0; k < run_bytes.size(); k++) begin
      e.out_byte    = run_bytes[k];
      e.last_of_run = (k == run_bytes.size() - 1);
      expected_bytes.push_back(e);
    end
    items_sent++;
    kind_count[it.func]++;
  endtask

  // receiver pacing, with one long hold-off on request
  initial begin : sink_pacing
    int stall;
    int run;
    byte_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        byte_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end else begin
        stall = pick_gap();
        run   = calm ? 32 : $urandom_range(1, 12);
        if (stall > 0) begin
          byte_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        byte_ch.ready <= 1'b1;
        repeat (run) @(posedge clk);
      end
    end
  end

  // every accepted byte against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst && byte_ch.valid && byte_ch.ready) begin
      got = byte_ch.payload;
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] unexpected byte %h last %b", $realtime, got.out_byte,
                   got.last_of_run);
      end else begin
        want = expected_bytes.pop_front();
        if (got.out_byte !== want.out_byte || got.last_of_run !== want.last_of_run) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] byte %0d: expected %h last %b, got %h last %b", $realtime,
                     bytes_checked, want.out_byte, want.last_of_run, got.out_byte,
                     got.last_of_run);
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timed out after %0d cycles, %0d bytes outstanding", cycles,
             expected_bytes.size());
    $display("tek_vector_stream_encoder_core_test: FAIL");
    $finish;
  end

  initial begin : stimulus
    int       random_sent;
    int       body_len;
    int       noise_len;
    int       i;
    in_item_t it;
    item_ch.valid   <= 1'b0;
    item_ch.payload <= '0;
    forget_state();
    random_sent = 0;

    // directed table: golden bytes only where they are obvious
    add_row(FUNC_START, 8'hFF, '1, '1, '1, '1, 8'hFF, 8, {56'h0, ENTER_SEQ});
    // pen unknown, full-scale vector from the origin: the longest item
    add_row(FUNC_LINE, 8'h00, '0, '0, '1, '1, 8'h00, 15,
            120'h1B_60_1D_20_60_60_20_40_1D_07_3F_6F_7F_3F_5F);
    // continuing vector: end address only
    add_row(FUNC_LINE, 8'h00, '1, '1, '0, '0, 8'h00, 5, 120'h20_60_60_20_40);
    // font change at the pen, zero character byte
    add_row(FUNC_TEXT, 8'hFF, '0, '0, '1, '1, 8'h00, 4, 120'h1B_3B_1F_00);
    add_row(FUNC_TEXT, 8'hFF, '0, '0, '0, '0, 8'hFF, 1, 120'hFF);
    add_row(FUNC_TEXT, 8'hFF, 12'hFFF, 12'h000, '0, '0, 8'h41, 0, '0);
    add_row(FUNC_LINE, 8'hFF, 12'hFFF, 12'h000, 12'h000, 12'hFFF, 8'h00, 0, '0);
    add_row(FUNC_LINE, 8'h80, 12'hAAA, 12'h555, 12'h555, 12'hAAA, 8'h00, 0, '0);
    add_row(FUNC_LINE, 8'h80, 12'h555, 12'hAAA, 12'h123, 12'h456, 8'h00, 0, '0);
    // move without a mode change
    add_row(FUNC_LINE, 8'h80, 12'h7FF, 12'h800, 12'h800, 12'h7FF, 8'h00, 0, '0);
    add_row(FUNC_TEXT, 8'h02, 12'h800, 12'h7FF, '1, '1, 8'h20, 0, '0);
    add_row(FUNC_TEXT, 8'h02, 12'h800, 12'h7FF, '0, '0, 8'h7F, 0, '0);
    add_row(FUNC_END, 8'h00, '0, '0, '0, '0, 8'h00, 9, {48'h0, EXIT_SEQ});
    // end keeps state: no style or move here, only the way back to vector mode
    add_row(FUNC_LINE, 8'h80, 12'h800, 12'h7FF, '0, '0, 8'h00, 0, '0);
    add_row(FUNC_START, 8'h00, '0, '0, '0, '0, 8'h00, 8, {56'h0, ENTER_SEQ});
    // pen forgotten, so text at the origin still moves
    add_row(FUNC_TEXT, 8'h00, '0, '0, '0, '0, 8'h00, 0, '0);
    add_row(FUNC_END, 8'hFF, '1, '1, '1, '1, 8'hFF, 9, {48'h0, EXIT_SEQ});

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < directed_rows.size(); i++)
      send_item(directed_rows[i].item, int'(directed_rows[i].n_gold), directed_rows[i].gold);

    // random sessions, with a little noise between them
    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent >= 120 && !hold_off_done && !hold_off_req) hold_off_req = 1'b1;
      calm = (random_sent >= 200 && random_sent < 240);
      if ($urandom_range(0, 99) < 85) begin
        it      = rand_fields();
        it.func = FUNC_START;
        send_item(it, 0, '0);
        body_len = $urandom_range(3, 18);
        for (i = 0; i < body_len; i++) send_item(make_body(), 0, '0);
        it      = rand_fields();
        it.func = FUNC_END;
        send_item(it, 0, '0);
        random_sent += body_len + 2;
      end else begin
        noise_len = $urandom_range(1, 4);
        for (i = 0; i < noise_len; i++) send_item(rand_fields(), 0, '0);
        random_sent += noise_len;
      end
    end
    calm = 1'b0;
    item_ch.valid <= 1'b0;

    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items: %0d start, %0d line, %0d text, %0d end; %0d bytes checked",
             items_sent, kind_count[FUNC_START], kind_count[FUNC_LINE],
             kind_count[FUNC_TEXT], kind_count[FUNC_END], bytes_checked);
    $display("receiver hold-off of %0d cycles %s, %0d mismatches", HOLD_OFF_CYCLES,
             hold_off_done ? "done" : "missed", mismatches);
    if (mismatches == 0) begin
      $display("tek_vector_stream_encoder_core_test: PASS");
    end else begin
      $display("tek_vector_stream_encoder_core_test: FAIL");
    end
    $finish;
  end

endmodule
